[design/perspective_line_projector_core_assert.svh]
// Assertion macros for the perspective line projector
`ifndef PERSPECTIVE_LINE_PROJECTOR_CORE_ASSERT_SVH
`define PERSPECTIVE_LINE_PROJECTOR_CORE_ASSERT_SVH
`ifndef SYNTH
`define PLP_ASSERT_IMPL(lbl, clk, rst, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("plp assertion failed");
`define PLP_ASSERT_NEXT(lbl, clk, rst, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("plp assertion failed");
`else
`define PLP_ASSERT_IMPL(lbl, clk, rst, a, b)
`define PLP_ASSERT_NEXT(lbl, clk, rst, a, b)
`endif
`endif

[design/plp_pkg.sv]
// Shared constants, the point type and the clamp function of the perspective line projector
`default_nettype none
package plp_pkg;
  localparam int NUM_W = 40;
  localparam int DEN_W = 33;
  localparam logic signed [31:0] DEPTH_MIN = 32'sh400;
  localparam logic [DEN_W-1:0] DEPTH_FAR = 33'h2000;

  localparam logic [2:0] CFG_ROW_X = 3'd0;
  localparam logic [2:0] CFG_ROW_Y = 3'd1;
  localparam logic [2:0] CFG_ROW_DEPTH = 3'd2;
  localparam logic [2:0] CFG_OFFSET_X = 3'd3;
  localparam logic [2:0] CFG_OFFSET_Y = 3'd4;
  localparam logic [2:0] CFG_OFFSET_DEPTH = 3'd5;
  localparam logic [2:0] CFG_CENTER_X = 3'd6;
  localparam logic [2:0] CFG_CENTER_Y = 3'd7;

  // transformed point leaving the matrix stages
  typedef struct packed {
    logic valid;
    logic signed [31:0] dx;
    logic signed [31:0] dy;
    logic signed [31:0] depth;
    logic [8:0] alpha;
  } xform_t;

  // clamp to signed 16 bits
  function automatic logic signed [15:0] sat16(input logic signed [33:0] v);
    logic signed [15:0] r;
    if (v > 34'sd32767) r = 16'sh7fff;
    else if (v < -34'sd32768) r = 16'sh8000;
    else r = v[15:0];
    return r;
  endfunction
endpackage
`default_nettype wire

[design/plp_if.sv]
// Channel interfaces: point input, line output and register write
`default_nettype none
interface plp_point_if;
  logic valid;
  logic ready;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic signed [31:0] point_z;
  logic [8:0] alpha_in;
  modport source(output valid, point_x, point_y, point_z, alpha_in, input ready);
  modport sink(input valid, point_x, point_y, point_z, alpha_in, output ready);
endinterface

interface plp_line_if;
  logic valid;
  logic ready;
  logic signed [15:0] start_col;
  logic signed [15:0] start_row;
  logic signed [15:0] end_col;
  logic signed [15:0] end_row;
  logic [8:0] alpha_out;
  modport source(output valid, start_col, start_row, end_col, end_row, alpha_out,
                 input ready);
  modport sink(input valid, start_col, start_row, end_col, end_row, alpha_out,
               output ready);
endinterface

interface plp_cfg_if;
  logic valid;
  logic ready;
  logic [2:0] index;
  logic [47:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

[design/plp_transform.sv]
// Matrix stages: input shift, nine products, row sums with offsets
`default_nettype none
module plp_transform (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic in_valid,
  input  logic signed [31:0] point_x,
  input  logic signed [31:0] point_y,
  input  logic signed [31:0] point_z,
  input  logic [8:0] alpha_in,
  input  logic [47:0] row_x_coefs,
  input  logic [47:0] row_y_coefs,
  input  logic [47:0] row_depth_coefs,
  input  logic signed [31:0] offset_x,
  input  logic signed [31:0] offset_y,
  input  logic signed [31:0] offset_depth,
  output plp_pkg::xform_t xf
);
  logic [47:0] coefs [0:2];
  logic signed [23:0] pt [0:2];
  logic signed [39:0] prod [0:2][0:2];
  logic [8:0] alpha1, alpha2;
  logic v1, v2;

  assign coefs[0] = row_x_coefs;
  assign coefs[1] = row_y_coefs;
  assign coefs[2] = row_depth_coefs;

  // stage 1: drop the low 8 fraction bits
  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (en) v1 <= in_valid;
    if (en) begin
      pt[0] <= point_x[31:8];
      pt[1] <= point_y[31:8];
      pt[2] <= point_z[31:8];
      alpha1 <= alpha_in;
    end
  end

  // stage 2: 24x16 products, one per row and axis
  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (en) v2 <= v1;
    if (en) begin
      alpha2 <= alpha1;
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          prod[r][c] <= pt[c] * $signed(coefs[r][16*c +: 16]);
        end
      end
    end
  end

  // stage 3: shifted products plus offset, wrapping at 32 bits
  always_ff @(posedge clk) begin
    if (rst) xf.valid <= 1'b0;
    else if (en) xf.valid <= v2;
    if (en) begin
      xf.alpha <= alpha2;
      xf.dx <= offset_x + $signed(prod[0][0][39:8]) + $signed(prod[0][1][39:8])
               + $signed(prod[0][2][39:8]);
      xf.dy <= offset_y + $signed(prod[1][0][39:8]) + $signed(prod[1][1][39:8])
               + $signed(prod[1][2][39:8]);
      xf.depth <= offset_depth + $signed(prod[2][0][39:8])
                  + $signed(prod[2][1][39:8]) + $signed(prod[2][2][39:8]);
    end
  end
endmodule
`default_nettype wire

[design/plp_div.sv]
// Pipelined restoring divider, one quotient bit per stage
`default_nettype none
module plp_div #(
  parameter int NUM_W = plp_pkg::NUM_W,
  parameter int DEN_W = plp_pkg::DEN_W,
  parameter int TAG_W = 1
) (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic in_valid,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  input  logic [TAG_W-1:0] tag_in,
  output logic out_valid,
  output logic [NUM_W-1:0] quot,
  output logic [TAG_W-1:0] tag_out
);
  logic valid [0:NUM_W];
  logic [NUM_W-1:0] acc [0:NUM_W];
  logic [DEN_W-1:0] rem [0:NUM_W];
  logic [DEN_W-1:0] dv [0:NUM_W];
  logic [TAG_W-1:0] tag [0:NUM_W];

  assign valid[0] = in_valid;
  assign acc[0] = num;
  assign rem[0] = '0;
  assign dv[0] = den;
  assign tag[0] = tag_in;

  // each stage shifts one dividend bit into the remainder
  for (genvar k = 0; k < NUM_W; k++) begin : g_step
    logic [DEN_W:0] trial;
    logic [DEN_W:0] diff;
    logic take;
    assign trial = {rem[k], acc[k][NUM_W-1]};
    assign diff = trial - {1'b0, dv[k]};
    assign take = (trial >= {1'b0, dv[k]});
    always_ff @(posedge clk) begin
      if (rst) valid[k+1] <= 1'b0;
      else if (en) valid[k+1] <= valid[k];
      if (en) begin
        rem[k+1] <= take ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        acc[k+1] <= {acc[k][NUM_W-2:0], take};
        dv[k+1] <= dv[k];
        tag[k+1] <= tag[k];
      end
    end
  end

  assign out_valid = valid[NUM_W];
  assign quot = acc[NUM_W];
  assign tag_out = tag[NUM_W];
endmodule
`default_nettype wire

[design/perspective_line_projector_core.sv]
// Top level of the perspective line projector
`default_nettype none
// Projects one 16.16 world point per beat through a 3x4 camera matrix and
// emits a screen line segment from depth to depth plus 0x2000; points with
// depth below 0x400 give no beat. A new point is taken every cycle unless the
// output stalls, and passes three matrix stages, one range check stage,
// the 40-stage bit-per-stage dividers (four in parallel) and the output
// register. A stall on the output freezes the whole pipeline. Register
// writes are always taken and must only be made while the pipeline is empty.
module perspective_line_projector_core (
  input  logic clk,
  input  logic rst,
  plp_point_if.sink point_in,
  plp_line_if.source line_out,
  plp_cfg_if.sink cfg
);
  `include "perspective_line_projector_core_assert.svh"
  localparam int NW = plp_pkg::NUM_W;
  localparam int DW = plp_pkg::DEN_W;

  logic [47:0] row_x_coefs, row_y_coefs, row_depth_coefs;
  logic signed [31:0] offset_x, offset_y, offset_depth;
  logic [11:0] center_x, center_y;
  logic adv;
  plp_pkg::xform_t xf;

  logic s4_valid;
  logic [NW-1:0] num_x, num_y;
  logic neg_x, neg_y;
  logic [DW-1:0] den_near, den_far;
  logic [8:0] s4_alpha;

  logic [NW-1:0] q0, q1, q2, q3;
  logic dv0, dv1, dv2, dv3;
  logic [9:0] t0;
  logic t1, t2, t3;
  logic signed [31:0] sx0, sy0, sx1, sy1;
  logic o_valid;

  // register writes
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      row_x_coefs <= '0;
      row_y_coefs <= '0;
      row_depth_coefs <= '0;
      offset_x <= '0;
      offset_y <= '0;
      offset_depth <= '0;
      center_x <= 12'd212;
      center_y <= 12'd120;
    end else if (cfg.valid) begin
      case (cfg.index)
        plp_pkg::CFG_ROW_X: row_x_coefs <= cfg.data;
        plp_pkg::CFG_ROW_Y: row_y_coefs <= cfg.data;
        plp_pkg::CFG_ROW_DEPTH: row_depth_coefs <= cfg.data;
        plp_pkg::CFG_OFFSET_X: offset_x <= cfg.data[31:0];
        plp_pkg::CFG_OFFSET_Y: offset_y <= cfg.data[31:0];
        plp_pkg::CFG_OFFSET_DEPTH: offset_depth <= cfg.data[31:0];
        plp_pkg::CFG_CENTER_X: center_x <= cfg.data[11:0];
        plp_pkg::CFG_CENTER_Y: center_y <= cfg.data[11:0];
        default: ;
      endcase
    end
  end

  // whole pipeline moves unless the output beat is stuck
  assign adv = !o_valid || line_out.ready;
  assign point_in.ready = adv;

  plp_transform u_xform (
    .clk(clk), .rst(rst), .en(adv),
    .in_valid(point_in.valid),
    .point_x(point_in.point_x), .point_y(point_in.point_y),
    .point_z(point_in.point_z), .alpha_in(point_in.alpha_in),
    .row_x_coefs(row_x_coefs), .row_y_coefs(row_y_coefs),
    .row_depth_coefs(row_depth_coefs),
    .offset_x(offset_x), .offset_y(offset_y), .offset_depth(offset_depth),
    .xf(xf)
  );

  // stage 4: depth check, magnitudes and divisors
  always_ff @(posedge clk) begin
    if (rst) s4_valid <= 1'b0;
    else if (adv) s4_valid <= xf.valid && (xf.depth >= plp_pkg::DEPTH_MIN);
    if (adv) begin
      neg_x <= xf.dx[31];
      neg_y <= xf.dy[31];
      num_x <= xf.dx[31] ? -{xf.dx, 8'h00} : {xf.dx, 8'h00};
      num_y <= xf.dy[31] ? -{xf.dy, 8'h00} : {xf.dy, 8'h00};
      den_near <= {1'b0, xf.depth};
      den_far <= {1'b0, xf.depth} + plp_pkg::DEPTH_FAR;
      s4_alpha <= xf.alpha;
    end
  end

  plp_div #(.NUM_W(NW), .DEN_W(DW), .TAG_W(10)) u_div_xn (
    .clk(clk), .rst(rst), .en(adv), .in_valid(s4_valid),
    .num(num_x), .den(den_near), .tag_in({s4_alpha, neg_x}),
    .out_valid(dv0), .quot(q0), .tag_out(t0)
  );
  plp_div #(.NUM_W(NW), .DEN_W(DW), .TAG_W(1)) u_div_yn (
    .clk(clk), .rst(rst), .en(adv), .in_valid(s4_valid),
    .num(num_y), .den(den_near), .tag_in(neg_y),
    .out_valid(dv1), .quot(q1), .tag_out(t1)
  );
  plp_div #(.NUM_W(NW), .DEN_W(DW), .TAG_W(1)) u_div_xf (
    .clk(clk), .rst(rst), .en(adv), .in_valid(s4_valid),
    .num(num_x), .den(den_far), .tag_in(neg_x),
    .out_valid(dv2), .quot(q2), .tag_out(t2)
  );
  plp_div #(.NUM_W(NW), .DEN_W(DW), .TAG_W(1)) u_div_yf (
    .clk(clk), .rst(rst), .en(adv), .in_valid(s4_valid),
    .num(num_y), .den(den_far), .tag_in(neg_y),
    .out_valid(dv3), .quot(q3), .tag_out(t3)
  );

  // restore quotient signs (magnitudes stay below 2^30)
  assign sx0 = t0[0] ? -$signed(q0[31:0]) : $signed(q0[31:0]);
  assign sy0 = t1 ? -$signed(q1[31:0]) : $signed(q1[31:0]);
  assign sx1 = t2 ? -$signed(q2[31:0]) : $signed(q2[31:0]);
  assign sy1 = t3 ? -$signed(q3[31:0]) : $signed(q3[31:0]);

  // output register: centre offset and clamp
  always_ff @(posedge clk) begin
    if (rst) o_valid <= 1'b0;
    else if (adv) o_valid <= dv0;
    if (adv) begin
      line_out.start_col <= plp_pkg::sat16($signed({22'd0, center_x}) + 34'(sx0));
      line_out.start_row <= plp_pkg::sat16($signed({22'd0, center_y}) - 34'(sy0));
      line_out.end_col <= plp_pkg::sat16($signed({22'd0, center_x}) + 34'(sx1));
      line_out.end_row <= plp_pkg::sat16($signed({22'd0, center_y}) - 34'(sy1));
      line_out.alpha_out <= t0[9:1];
    end
  end
  assign line_out.valid = o_valid;

  // checks
  `PLP_ASSERT_IMPL(a_div_min, clk, rst, s4_valid, den_near >= 33'h400)
  `PLP_ASSERT_IMPL(a_quot_range, clk, rst, dv0, q0[39:30] == 10'd0 && q1[39:30] == 10'd0)
  `PLP_ASSERT_IMPL(a_div_lockstep, clk, rst, dv0 || dv1 || dv2 || dv3, dv0 && dv1 && dv2 && dv3)
  `PLP_ASSERT_NEXT(a_stall_hold, clk, rst, !adv, $stable(s4_valid) && $stable(dv0))
endmodule
`default_nettype wire
